/* hdl/rtty_symbol_framer_core_defines.svh */
// Assertion macros shared by the RTTY symbol framer RTL.
`ifndef RTTY_SYMBOL_FRAMER_CORE_DEFINES_SVH
`define RTTY_SYMBOL_FRAMER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RSF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rsf assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define RSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rsf assertion failed");

`endif

/* hdl/rsf_pkg.sv */
// Package with types and constants of the RTTY symbol framer.
`default_nettype none
package rsf_pkg;

	localparam int MAX_PREAMBLE = 32;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [7:0] MARK_BYTE  = 8'hFF;
	localparam logic [7:0] SPACE_BYTE = 8'h00;

	localparam logic KIND_MESSAGE = 1'b0;
	localparam logic KIND_CHAR    = 1'b1;

	localparam logic [1:0] CFG_DATA_BITS = 2'd0;
	localparam logic [1:0] CFG_OVERSAMPLE = 2'd1;
	localparam logic [1:0] CFG_PREAMBLE  = 2'd2;

	localparam logic [3:0] DATA_BITS_RESET  = 4'd8;
	localparam logic [1:0] OVERSAMPLE_RESET = 2'd1;
	localparam logic [5:0] PREAMBLE_RESET   = 6'd8;

	typedef enum logic [1:0] {
		ROLE_PREAMBLE = 2'd0,
		ROLE_START    = 2'd1,
		ROLE_DATA     = 2'd2,
		ROLE_STOP     = 2'd3
	} role_t;

	// One classified item: what the back end has to send.
	typedef struct packed {
		logic       kind;
		logic [7:0] chr;
		logic [5:0] sym_count;
		logic       double_rep;
	} desc_t;

endpackage
`default_nettype wire

/* hdl/rsf_front.sv */
// Front end: configuration registers, item intake and classification.
`default_nettype none
module rsf_front #(
	parameter int MAX_PREAMBLE = rsf_pkg::MAX_PREAMBLE
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_write,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [5:0]    cfg_data,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          kind,
	input  wire logic [7:0]    char_byte,
	output logic               push_valid,
	input  wire logic          push_ready,
	output rsf_pkg::desc_t     push_desc
);

	logic [3:0] data_bits_q;
	logic [1:0] oversample_q;
	logic [5:0] preamble_q;

	logic           valid_s1;
	rsf_pkg::desc_t desc_s1;

	logic           accept;
	logic [3:0]     nbits;
	logic [5:0]     pre;
	logic           keep;
	rsf_pkg::desc_t desc_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_bits_q  <= rsf_pkg::DATA_BITS_RESET;
			oversample_q <= rsf_pkg::OVERSAMPLE_RESET;
			preamble_q   <= rsf_pkg::PREAMBLE_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				rsf_pkg::CFG_DATA_BITS:  data_bits_q  <= cfg_data[3:0];
				rsf_pkg::CFG_OVERSAMPLE: oversample_q <= cfg_data[1:0];
				rsf_pkg::CFG_PREAMBLE:   preamble_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (data_bits_q < 4'd7) begin
			nbits = 4'd7;
		end else if (data_bits_q > 4'd8) begin
			nbits = 4'd8;
		end else begin
			nbits = data_bits_q;
		end
		pre = (preamble_q > 6'(MAX_PREAMBLE)) ? 6'(MAX_PREAMBLE) : preamble_q;

		desc_new.kind       = kind;
		desc_new.chr        = char_byte;
		desc_new.double_rep = oversample_q[1];
		if (kind == rsf_pkg::KIND_CHAR) begin
			// start, data bits and two stops
			desc_new.sym_count = 6'(nbits) + 6'd3;
			keep = 1'b1;
		end else begin
			desc_new.sym_count = pre;
			keep = (pre != 6'd0);
		end
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign accept     = in_valid && in_ready;
	assign push_valid = valid_s1;
	assign push_desc  = desc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= desc_new;
		end
	end

endmodule
`default_nettype wire

/* hdl/rsf_queue.sv */
// Short descriptor queue between the front end and the symbol sequencer.
`default_nettype none
`include "rtty_symbol_framer_core_defines.svh"
module rsf_queue #(
	parameter int DEPTH = rsf_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire rsf_pkg::desc_t push_desc,
	output logic                pop_valid,
	input  wire logic           pop_ready,
	output rsf_pkg::desc_t      pop_desc
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rsf_pkg::desc_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic push_fire;
	logic pop_fire;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_desc   = entries_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			entries_q[wr_ptr_q] <= push_desc;
		end
	end

	`RSF_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(DEPTH))
	`RSF_ASSERT_NEXT(a_pop_drains, clk, arst_n, pop_fire && !push_fire, count_q == $past(count_q) - 1'b1)

endmodule
`default_nettype wire

/* hdl/rsf_back.sv */
// Back end: symbol sequencer with its output register.
`default_nettype none
`include "rtty_symbol_framer_core_defines.svh"
module rsf_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	output logic                q_ready,
	input  wire rsf_pkg::desc_t q_desc,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [7:0]          symbol_byte,
	output logic [1:0]          symbol_role,
	output logic                last
);

	logic           busy_q;
	rsf_pkg::desc_t desc_q;
	logic [5:0]     sym_q;
	logic           rep_q;

	logic           out_valid_q;
	logic [7:0]     out_byte_q;
	rsf_pkg::role_t out_role_q;
	logic           out_last_q;

	logic           emit;
	logic           final_rep;
	logic           final_sym;
	logic           item_done;
	logic           load;
	logic [2:0]     bit_idx;
	rsf_pkg::role_t role;
	logic [7:0]     sym_byte;

	always_comb begin
		emit      = busy_q && (!out_valid_q || out_ready);
		final_rep = !desc_q.double_rep || rep_q;
		final_sym = (sym_q == desc_q.sym_count - 6'd1);
		item_done = emit && final_rep && final_sym;
		q_ready   = !busy_q || item_done;
		load      = q_valid && q_ready;
		bit_idx   = 3'(sym_q - 6'd1);

		if (desc_q.kind == rsf_pkg::KIND_MESSAGE) begin
			role     = rsf_pkg::ROLE_PREAMBLE;
			sym_byte = rsf_pkg::MARK_BYTE;
		end else if (sym_q == 6'd0) begin
			role     = rsf_pkg::ROLE_START;
			sym_byte = rsf_pkg::SPACE_BYTE;
		end else if (sym_q >= desc_q.sym_count - 6'd2) begin
			role     = rsf_pkg::ROLE_STOP;
			sym_byte = rsf_pkg::MARK_BYTE;
		end else begin
			role     = rsf_pkg::ROLE_DATA;
			sym_byte = desc_q.chr[bit_idx] ? rsf_pkg::MARK_BYTE : rsf_pkg::SPACE_BYTE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sym_q  <= '0;
			rep_q  <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
			sym_q  <= '0;
			rep_q  <= 1'b0;
		end else if (item_done) begin
			busy_q <= 1'b0;
		end else if (emit) begin
			if (final_rep) begin
				rep_q <= 1'b0;
				sym_q <= sym_q + 6'd1;
			end else begin
				rep_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			desc_q <= q_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= sym_byte;
			out_role_q <= role;
			out_last_q <= final_rep && final_sym;
		end
	end

	assign out_valid   = out_valid_q;
	assign symbol_byte = out_byte_q;
	assign symbol_role = out_role_q;
	assign last        = out_last_q;

	`RSF_ASSERT_IMPL(a_sym_in_range, clk, arst_n, busy_q, sym_q < desc_q.sym_count)
	`RSF_ASSERT_IMPL(a_start_is_space, clk, arst_n, out_valid_q && (out_role_q == rsf_pkg::ROLE_START), out_byte_q == rsf_pkg::SPACE_BYTE)

endmodule
`default_nettype wire

/* hdl/rtty_symbol_framer_core.sv */
// Top level of the RTTY symbol framer: front end, descriptor queue, sequencer.
//
// Channel   Direction  Handshake             Payload
// cfg       in         cfg_write             cfg_index, cfg_data
// in        in         in_valid / in_ready   kind, char_byte
// out       out        out_valid / out_ready symbol_byte, symbol_role, last
//
// A character transaction yields (data_bits + 3) output transactions, a
// begin-message one preamble_symbols, with data_bits held to 7..8, the
// preamble to MAX_PREAMBLE, both doubled if oversample bit 1 is set: at most
// 22 per character. The sequencer emits one symbol byte per cycle unless
// the output stalls and loads the next descriptor in the cycle of the last
// byte. An accepted item passes the front-end register, queue and descriptor
// register to the output register. Input is taken while the queue has room,
// even if the output stalls. Reset clears all control state at once.
`default_nettype none
module rtty_symbol_framer_core #(
	parameter int MAX_PREAMBLE = rsf_pkg::MAX_PREAMBLE,
	parameter int QUEUE_DEPTH  = rsf_pkg::QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_write,
	input  wire logic [1:0] cfg_index,
	input  wire logic [5:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       kind,
	input  wire logic [7:0] char_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      symbol_byte,
	output logic [1:0]      symbol_role,
	output logic            last
);

	// Descriptor handoff from the front end into the queue.
	logic           push_valid;
	logic           push_ready;
	rsf_pkg::desc_t push_desc;

	// Descriptor handoff from the queue into the sequencer.
	logic           pop_valid;
	logic           pop_ready;
	rsf_pkg::desc_t pop_desc;

	// The front end holds the configuration registers and turns each
	// transaction into a descriptor: symbol count, repeat flag and character.
	// Begin-message transactions with an empty preamble are dropped here.
	rsf_front #(
		.MAX_PREAMBLE(MAX_PREAMBLE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.char_byte  (char_byte),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc)
	);

	// The queue lets the front end run ahead while the output is stalled.
	rsf_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_desc   (pop_desc)
	);

	// The sequencer walks the symbols of one descriptor, repeating each one
	// when bit 1 of oversample is set, and flags the final byte of the transaction.
	rsf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (pop_valid),
		.q_ready     (pop_ready),
		.q_desc      (pop_desc),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.symbol_byte (symbol_byte),
		.symbol_role (symbol_role),
		.last        (last)
	);

endmodule
`default_nettype wire
